// File: rtl/core/vtpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vtpd_pkg;

    // Width of the exact Q36.32 column sums.
    localparam int SumW = 68;
    // Width of the divider remainder: numerator and the divisor shifted by the top step.
    localparam int DivW = 101;
    // Quotient bits produced, one per divider stage.
    localparam int QBits = 33;

    typedef struct packed {
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               w_was_zero;
        logic               saturated;
    } t_out;

    // Matrix of coefficients, indexed [row][column].
    typedef logic signed [3:0][3:0][31:0] t_coef;

    // One division lane.
    typedef struct packed {
        logic [DivW-1:0]  rem;
        logic [QBits-1:0] q;
        logic             neg;
        logic             ovf;
    } t_lane;

    // Word travelling through the divider.
    typedef struct packed {
        t_lane [2:0]     lane;
        logic [DivW-1:0] d;
        logic            wzero;
    } t_div;

endpackage
`default_nettype wire

// File: rtl/core/vertex_transform_perspective_divide_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Vertex transform with perspective divide.
// Input channel: i_in_valid / o_in_ready carry one vertex word (x, y, z, Q16.16).
// Output channel: o_out_valid / i_out_ready carry one result word per vertex:
// x, y, z divided by w (truncated toward zero), a flag for w equal to zero and
// a flag for clamping to the 32-bit range.
// The matrix sits in eight 64-bit registers written through i_cfg_we,
// i_cfg_idx and i_cfg_data; indexes eight and above are ignored. Write them
// only while no vertex is in flight.
// A vertex passes two multiply-accumulate stages, two sign and divisor
// setup stages, 33 divider stages (one quotient bit per stage) and the
// clamp and output register. One vertex is taken every cycle unless the receiver stalls.
// Reset loads the identity matrix and empties the pipeline.
// When the receiver stalls, the whole pipeline holds in place and
// o_in_ready drops, so no word is lost or repeated.
module vertex_transform_perspective_divide_top import vtpd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_data
);

    logic [7:0][63:0]         r_cfg;
    t_coef                    coef;
    logic                     en;
    logic                     mac_v, prep_v, div_v;
    logic signed [3:0][SumW-1:0] mac_sum;
    t_div                     prep_d, div_d;
    logic                     r_out_v;
    t_out                     r_out;
    t_out                     n_out;
    logic [2:0][31:0]         res;
    logic [2:0]               sat;

    // Matrix registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[0] <= 64'h0000_0000_0001_0000;
            r_cfg[1] <= 64'h0;
            r_cfg[2] <= 64'h0001_0000_0000_0000;
            r_cfg[3] <= 64'h0;
            r_cfg[4] <= 64'h0;
            r_cfg[5] <= 64'h0000_0000_0001_0000;
            r_cfg[6] <= 64'h0;
            r_cfg[7] <= 64'h0001_0000_0000_0000;
        end else if (i_cfg_we && !i_cfg_idx[3]) begin
            r_cfg[i_cfg_idx[2:0]] <= i_cfg_data;
        end
    end

    // Coefficient m[r][c] lives in register 2r + c/2, half c%2.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                coef[r][c] = r_cfg[r*2 + c/2][(c%2)*32 +: 32];
            end
        end
    end

    // The pipeline advances unless a result waits and is not taken.
    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en;

    vtpd_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_coef  (coef),
        .o_valid (mac_v),
        .o_sum   (mac_sum)
    );

    vtpd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (mac_v),
        .i_sum   (mac_sum),
        .o_valid (prep_v),
        .o_div   (prep_d)
    );

    vtpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (prep_v),
        .i_div   (prep_d),
        .o_valid (div_v),
        .o_div   (div_d)
    );

    // Clamp each quotient to the signed 32-bit range and apply the sign.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (div_d.lane[c].neg) begin
                sat[c] = div_d.lane[c].ovf || (div_d.lane[c].q > QBits'(33'h0_8000_0000));
                res[c] = sat[c] ? 32'h8000_0000 : 32'(-div_d.lane[c].q);
            end else begin
                sat[c] = div_d.lane[c].ovf || (div_d.lane[c].q > QBits'(33'h0_7FFF_FFFF));
                res[c] = sat[c] ? 32'h7FFF_FFFF : div_d.lane[c].q[31:0];
            end
        end
        n_out.out_x      = res[0];
        n_out.out_y      = res[1];
        n_out.out_z      = res[2];
        n_out.w_was_zero = div_d.wzero;
        n_out.saturated  = |sat;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

// File: rtl/core/vtpd_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module vtpd_mac import vtpd_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_en,
    input  wire logic                  i_valid,
    input  wire t_in                   i_data,
    input  wire t_coef                 i_coef,
    output logic                       o_valid,
    output logic signed [3:0][SumW-1:0] o_sum
);

    logic signed [2:0][3:0][63:0] r_prod;
    logic signed [3:0][31:0]      r_tr;
    logic signed [3:0][SumW-1:0]  r_sum;
    logic                         r_v1, r_v2;
    logic signed [2:0][31:0]      v;

    assign v[0] = i_data.in_x;
    assign v[1] = i_data.in_y;
    assign v[2] = i_data.in_z;

    // Valid bits of the product and sum stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: the twelve exact products and the translation terms.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r][c] <= $signed(v[r]) * $signed(i_coef[r][c]);
                end
            end
            for (int c = 0; c < 4; c++) begin
                r_tr[c] <= i_coef[3][c];
            end
        end
    end

    // Stage two: column sums in Q36.32.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_sum[c] <= SumW'($signed(r_prod[0][c])) + SumW'($signed(r_prod[1][c]))
                          + SumW'($signed(r_prod[2][c]))
                          + SumW'($signed({r_tr[c], 32'd0}));
            end
        end
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;

endmodule
`default_nettype wire

// File: rtl/core/vtpd_prep.sv
`timescale 1ns / 1ps
`default_nettype none
module vtpd_prep import vtpd_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic signed [3:0][SumW-1:0] i_sum,
    output logic                        o_valid,
    output t_div                        o_div
);

    logic [3:0][SumW-1:0] r_mag;
    logic [3:0]           r_neg;
    logic                 r_wzero;
    logic                 r_v1, r_v2;
    t_div                 r_div;
    t_div                 n_div;
    logic [DivW-1:0]      d_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Stage one: split each sum into sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_neg[c] <= i_sum[c][SumW-1];
                r_mag[c] <= i_sum[c][SumW-1] ? SumW'(-i_sum[c]) : SumW'(i_sum[c]);
            end
            r_wzero <= (i_sum[3] == '0);
        end
    end

    // Stage two: numerators, divisor and the early overflow test.
    // A zero w divides the value scaled down by 2^16 by one.
    always_comb begin
        n_div       = r_div;
        n_div.wzero = r_wzero;
        n_div.d     = r_wzero ? DivW'(1) : DivW'(r_mag[3]);
        d_top       = n_div.d << QBits;
        for (int c = 0; c < 3; c++) begin
            n_div.lane[c].rem = r_wzero ? DivW'(r_mag[c] >> 16) : (DivW'(r_mag[c]) << 16);
            n_div.lane[c].q   = '0;
            n_div.lane[c].neg = r_wzero ? r_neg[c] : (r_neg[c] ^ r_neg[3]);
            n_div.lane[c].ovf = (n_div.lane[c].rem >= d_top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_v2;
    assign o_div   = r_div;

endmodule
`default_nettype wire

// File: rtl/core/vtpd_div.sv
`timescale 1ns / 1ps
`default_nettype none
module vtpd_div import vtpd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_div i_div,
    output logic      o_valid,
    output t_div      o_div
);

    t_div r_st [0:QBits];
    logic r_v  [0:QBits];

    assign r_st[0] = i_div;
    assign r_v[0]  = i_valid;

    // One restoring step per stage, most significant quotient bit first.
    for (genvar s = 0; s < QBits; s++) begin : g_step
        localparam int K = QBits - 1 - s;
        t_div            n_st;
        logic [DivW-1:0] ds;

        always_comb begin
            n_st = r_st[s];
            ds   = r_st[s].d << K;
            for (int c = 0; c < 3; c++) begin
                if (r_st[s].lane[c].rem >= ds) begin
                    n_st.lane[c].rem  = r_st[s].lane[c].rem - ds;
                    n_st.lane[c].q[K] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s+1] <= 1'b0;
            end else if (i_en) begin
                r_v[s+1] <= r_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s+1] <= n_st;
            end
        end
    end

    assign o_valid = r_v[QBits];
    assign o_div   = r_st[QBits];

endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import vtpd_pkg::*;

    localparam int DrainCycles = 45;
    localparam int IdleLimit   = 4000;
    localparam int RandPhases  = 9;
    localparam int WordsPerPhase = 150;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_idx;
    logic [63:0] i_cfg_data;

    vertex_transform_perspective_divide_top DUT (.*);

    // Directed row: one vertex and, where obvious, its result.
    typedef struct {
        t_in  vtx;
        bit   known;
        t_out res;
    } t_row;

    logic [63:0] matrix_regs [8];
    t_out        pending_results [$];
    int          errors = 0;
    int          words_out = 0;
    int          idle_cycles = 0;
    int          cfg_writes = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Pull one signed Q16.16 coefficient out of the register copy.
    function automatic logic signed [31:0] coef(int r, int c);
        logic [63:0] reg_val;
        reg_val = matrix_regs[r * 2 + c / 2];
        return (c % 2) ? reg_val[63:32] : reg_val[31:0];
    endfunction

    // Saturate a sign-magnitude quotient to 32 bits.
    function automatic logic [31:0] clamp_q(bit neg, logic [127:0] mag, ref bit sat);
        if (!neg) begin
            if (mag > 128'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return mag[31:0];
        end
        if (mag > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -mag[31:0];
    endfunction

    // Transform one vertex and divide by w, exactly as the block should.
    function automatic t_out transform_vertex(t_in v);
        logic signed [127:0] sums [4];
        logic signed [31:0]  comp [3];
        logic signed [63:0]  prod;
        logic [127:0]        wmag;
        logic [127:0]        mag;
        logic [127:0]        quo;
        logic [31:0]         outs [3];
        bit                  wneg;
        bit                  sneg;
        bit                  wzero;
        bit                  sat;
        t_out                r;
        comp[0] = v.in_x;
        comp[1] = v.in_y;
        comp[2] = v.in_z;
        sat = 1'b0;
        for (int c = 0; c < 4; c++) begin
            sums[c] = 128'(signed'(coef(3, c))) <<< 32;
            for (int k = 0; k < 3; k++) begin
                prod = 64'(comp[k]) * 64'(coef(k, c));
                sums[c] = sums[c] + 128'(prod);
            end
        end
        wneg  = sums[3][127];
        wmag  = wneg ? -sums[3] : sums[3];
        wzero = (sums[3] == 0);
        for (int c = 0; c < 3; c++) begin
            sneg = sums[c][127];
            mag  = sneg ? -sums[c] : sums[c];
            if (wzero) begin
                quo = mag >> 16;
                outs[c] = clamp_q(sneg, quo, sat);
            end else begin
                quo = (mag << 16) / wmag;
                outs[c] = clamp_q(sneg != wneg, quo, sat);
            end
        end
        r.out_x      = outs[0];
        r.out_y      = outs[1];
        r.out_z      = outs[2];
        r.w_was_zero = wzero;
        r.saturated  = sat;
        return r;
    endfunction

    function automatic t_row mk_row(int x, int y, int z, bit known, int ex, int ey, int ez);
        t_row r;
        r.vtx   = '{in_x: x, in_y: y, in_z: z};
        r.known = known;
        r.res   = '{out_x: ex, out_y: ey, out_z: ez, w_was_zero: 1'b0, saturated: 1'b0};
        return r;
    endfunction

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 262143)) - 131072);
            2: return 32'h0;
            3: return 32'h0001_0000;
            default: return 32'($signed($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: return 32'h8000_0000 ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
            3: return 32'($signed($urandom_range(0, 255)) - 128);
            default: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
        endcase
    endfunction

    // Send one vertex word; the expectation is queued when it is taken.
    task automatic send_vertex(t_in v, bit known, t_out res);
        int gap;
        gap = $urandom_range(0, 3);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(known ? res : transform_vertex(v));
    endtask

    // Wait for the pipeline to empty before touching the matrix.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= 4'(idx);
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 8) matrix_regs[idx] = val;
        cfg_writes++;
    endtask

    // Output side: random stalls, each result word checked in order.
    initial begin
        int gap;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (o_out_valid && i_out_ready) begin
            words_out++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.out_x !== want.out_x) begin
                    $error("out_x expected %0d got %0d", want.out_x, o_out_data.out_x);
                    errors++;
                end
                if (o_out_data.out_y !== want.out_y) begin
                    $error("out_y expected %0d got %0d", want.out_y, o_out_data.out_y);
                    errors++;
                end
                if (o_out_data.out_z !== want.out_z) begin
                    $error("out_z expected %0d got %0d", want.out_z, o_out_data.out_z);
                    errors++;
                end
                if (o_out_data.w_was_zero !== want.w_was_zero) begin
                    $error("w_was_zero expected %0b got %0b", want.w_was_zero,
                           o_out_data.w_was_zero);
                    errors++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $error("saturated expected %0b got %0b", want.saturated,
                           o_out_data.saturated);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_row  rows [$];
        t_out  none;
        t_in   v;
        int    n_dir;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        none = '0;
        matrix_regs = '{64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
                        64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // After reset w is 2^48, so each component comes out as itself over 2^16.
        rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 0));
        rows.push_back(mk_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1, 1, 2, 3));
        rows.push_back(mk_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                              32767, 32767, 32767));
        rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                              -32768, -32768, -32768));
        rows.push_back(mk_row(-1, 1, -1, 1, 0, 0, 0));
        rows.push_back(mk_row(-65536, -131072, 65535, 1, -1, -2, 0));
        rows.push_back(mk_row(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 32767, -32768, 0));
        rows.push_back(mk_row(32'h1234_5678, -32'h0FED_CBA9, 32'h5555_5555, 0, 0, 0, 0));
        rows.push_back(mk_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000, 0, 0, 0, 0));
        rows.push_back(mk_row(-65537, 131071, 1, 0, 0, 0, 0));
        n_dir = rows.size();
        foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].known, rows[i].res);

        // Random matrices, zero w, the coefficient extremes, an all-zero matrix and a projection matrix.
        for (int ph = 0; ph < RandPhases; ph++) begin
            wait_idle();
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0: write_reg(k, {rand_coef(), rand_coef()});
                    1: write_reg(k, (k % 2) ? {32'h0, rand_coef()}
                                            : {rand_coef(), rand_coef()});
                    2: write_reg(k, 64'h8000_0000_8000_0000);
                    3: write_reg(k, 64'h7FFF_FFFF_7FFF_FFFF);
                    4: write_reg(k, 64'h0);
                    5: write_reg(k, {$urandom, $urandom});
                    6: write_reg(k, (k == 5) ? 64'h0001_0000_0001_0000 :
                                    (k == 7) ? 64'h0 :
                                    (k == 0 || k == 2) ? {rand_coef(), rand_coef()} :
                                    {32'h0, rand_coef()});
                    default: write_reg(k, {rand_coef(), rand_coef()});
                endcase
            end
            write_reg($urandom_range(8, 15), {$urandom, $urandom});
            for (int i = 0; i < WordsPerPhase; i++) begin
                v.in_x = rand_comp();
                v.in_y = rand_comp();
                v.in_z = rand_comp();
                send_vertex(v, 1'b0, none);
            end
        end

        wait_idle();
        $display("covered %0d directed and %0d random vertices, %0d register writes",
                 n_dir, RandPhases * WordsPerPhase, cfg_writes);
        $display("checked %0d result words", words_out);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
